// ===== src/gamma_correct_box_downscaler_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gamma-correct box downscaler
// Concurrent assertion forms used by the RTL sequencer, gcbd_ctrl.
// ----------------------------------------------------------------------------
`ifndef GAMMA_CORRECT_BOX_DOWNSCALER_CORE_MACROS_SVH
`define GAMMA_CORRECT_BOX_DOWNSCALER_CORE_MACROS_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define GCBD_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("gcbd: implication check failed");

// Next-cycle implication checked on every clock edge outside reset.
`define GCBD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("gcbd: sequence check failed");

`endif

// ===== src/gcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcbd_pkg
// Shared types, constants and lookup tables of the gamma-correct downscaler.
// ----------------------------------------------------------------------------
package gcbd_pkg;

  localparam int MAX_OUT_WIDTH_DEF  = 128;
  localparam int MAX_SOURCE_DIM_DEF = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q8      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HEIGHT = 3'd4;

  localparam logic [12:0] RST_SOURCE_WIDTH  = 13'd640;
  localparam logic [12:0] RST_SOURCE_HEIGHT = 13'd480;
  localparam logic [11:0] RST_SCALE_Q8      = 12'd1536;
  localparam logic [7:0]  RST_OUTPUT_WIDTH  = 8'd107;
  localparam logic [7:0]  RST_OUTPUT_HEIGHT = 8'd60;

  localparam logic [11:0] SCALE_ONE = 12'd256;

  localparam int SUM_W   = 24;
  localparam int CNT_W   = 9;
  localparam int LIN_W   = 16;
  localparam int LANES   = 3;
  localparam int CIDX_W  = 10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic acc_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_free;
  } status_t;

  typedef logic [LIN_W-1:0] expand_lut_t [256];
  typedef logic [7:0]       compress_lut_t [1024];

  // floor((c/255)^2.2 * 65535): largest v with v^5 * 255^11 <= 65535^5 * c^11.
  function automatic expand_lut_t build_expand_lut();
    expand_lut_t  t;
    logic [191:0] k255, k65535, lhs, rhs;
    int           lo, hi, mid, i;
    k255   = 192'd1;
    k65535 = 192'd1;
    for (i = 0; i < 11; i++) k255 = k255 * 192'd255;
    for (i = 0; i < 5; i++) k65535 = k65535 * 192'd65535;
    for (int c = 0; c < 256; c++) begin
      rhs = k65535;
      for (i = 0; i < 11; i++) rhs = rhs * 192'(c);
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = k255;
        for (i = 0; i < 5; i++) lhs = lhs * 192'(mid);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      t[c] = LIN_W'(lo);
    end
    return t;
  endfunction

  // floor(255 * (i/1023)^(1/2.2)): largest v with v^11 * 1023^5 <= 255^11 * i^5.
  function automatic compress_lut_t build_compress_lut();
    compress_lut_t t;
    logic [191:0]  k255, k1023, lhs, rhs;
    int            lo, hi, mid, i;
    k255  = 192'd1;
    k1023 = 192'd1;
    for (i = 0; i < 11; i++) k255 = k255 * 192'd255;
    for (i = 0; i < 5; i++) k1023 = k1023 * 192'd1023;
    for (int c = 0; c < 1024; c++) begin
      rhs = k255;
      for (i = 0; i < 5; i++) rhs = rhs * 192'(c);
      lo = 0;
      hi = 255;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = k1023;
        for (i = 0; i < 11; i++) lhs = lhs * 192'(mid);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      t[c] = 8'(lo);
    end
    return t;
  endfunction

  localparam expand_lut_t   EXPAND_LUT   = build_expand_lut();
  localparam compress_lut_t COMPRESS_LUT = build_compress_lut();

endpackage

// ===== src/gcbd_ifs.sv =====
// ----------------------------------------------------------------------------
// gcbd channel interfaces
// Valid/ready channels for source pixels and for output pixels.
// ----------------------------------------------------------------------------
interface gcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_start;

  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface gcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [6:0] out_column;
  logic [6:0] out_row;
  logic       frame_done;

  modport source (output valid, red_out, green_out, blue_out, out_column, out_row,
                  frame_done, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, out_column, out_row,
                  frame_done, output ready);
endinterface

// ===== src/gcbd_divider.sv =====
// ----------------------------------------------------------------------------
// gcbd_divider
// Three-lane restoring divider, one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module gcbd_divider
  import gcbd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [LANES-1:0][SUM_W-1:0]  dividend_i,
  input  logic [CNT_W-1:0]             divisor_i,
  output logic                         done_o,
  output logic [LANES-1:0][SUM_W-1:0]  quotient_o
);

  localparam int STEP_W = $clog2(SUM_W);

  logic                         busy_q;
  logic [STEP_W-1:0]            step_q;
  logic [CNT_W-1:0]             div_q;
  logic [LANES-1:0][SUM_W-1:0]  quo_q, quo_d;
  logic [LANES-1:0][CNT_W-1:0]  rem_q, rem_d;

  always_comb begin
    logic [CNT_W:0] trial;
    for (int l = 0; l < LANES; l++) begin
      trial = {rem_q[l], quo_q[l][SUM_W-1]};
      if (trial >= {1'b0, div_q}) begin
        rem_d[l] = CNT_W'(trial - {1'b0, div_q});
        quo_d[l] = {quo_q[l][SUM_W-2:0], 1'b1};
      end else begin
        rem_d[l] = CNT_W'(trial);
        quo_d[l] = {quo_q[l][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(SUM_W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // The final step happens in this cycle; the quotient is complete after it.
  assign done_o     = busy_q && (step_q == STEP_W'(SUM_W - 1));
  assign quotient_o = quo_q;

endmodule

// ===== src/gcbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcbd_ctrl
// Sequencer: accept, accumulate, divide and hand off one output pixel.
// ----------------------------------------------------------------------------
`include "gamma_correct_box_downscaler_core_macros.svh"

module gcbd_ctrl
  import gcbd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_step = 1'b1;
        state_d        = status_i.emit ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.load_out = status_i.out_free;
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `GCBD_ASSERT_NEXT(a_acc_single, clk_i, rst_ni, state_q == ST_ACC, state_q != ST_ACC)
  `GCBD_ASSERT_NEXT(a_div_to_out, clk_i, rst_ni, state_q == ST_DIV && status_i.div_done, state_q == ST_OUT)
  `GCBD_ASSERT_NEXT(a_quiet_item, clk_i, rst_ni, state_q == ST_ACC && !status_i.emit, state_q == ST_IDLE)

endmodule

// ===== src/gcbd_datapath.sv =====
// ----------------------------------------------------------------------------
// gcbd_datapath
// Window tracking, column accumulators, divider and output register.
// ----------------------------------------------------------------------------
module gcbd_datapath
  import gcbd_pkg::*;
#(
  parameter int MAX_OUT_WIDTH  = MAX_OUT_WIDTH_DEF,
  parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic [6:0]            out_column_o,
  output logic [6:0]            out_row_o,
  output logic                  frame_done_o
);

  localparam int DIM_W  = $clog2(MAX_SOURCE_DIM + 1);
  localparam int COL_W  = $clog2(MAX_OUT_WIDTH + 1);
  localparam int ADDR_W = $clog2(MAX_OUT_WIDTH);
  localparam int EDGE_W = $clog2((MAX_OUT_WIDTH + 2) * 4096);
  localparam int RE_W   = (DIM_W > 13) ? DIM_W : 13;
  localparam int WORD_W = LANES * SUM_W + CNT_W;

  // Configuration registers.
  logic [12:0] src_w_q, src_h_q;
  logic [11:0] scale_q;
  logic [7:0]  out_w_q, out_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= RST_SOURCE_WIDTH;
      src_h_q <= RST_SOURCE_HEIGHT;
      scale_q <= RST_SCALE_Q8;
      out_w_q <= RST_OUTPUT_WIDTH;
      out_h_q <= RST_OUTPUT_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SOURCE_WIDTH:  src_w_q <= cfg_data_i;
        REG_SOURCE_HEIGHT: src_h_q <= cfg_data_i;
        REG_SCALE_Q8:      scale_q <= cfg_data_i[11:0];
        REG_OUTPUT_WIDTH:  out_w_q <= cfg_data_i[7:0];
        REG_OUTPUT_HEIGHT: out_h_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Effective register values after clamping.
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [11:0]      s_eff;
  logic [COL_W-1:0] ow_eff;

  always_comb begin
    if (src_w_q == '0) w_eff = DIM_W'(1);
    else if (int'(src_w_q) > MAX_SOURCE_DIM) w_eff = DIM_W'(MAX_SOURCE_DIM);
    else w_eff = DIM_W'(src_w_q);
    if (src_h_q == '0) h_eff = DIM_W'(1);
    else if (int'(src_h_q) > MAX_SOURCE_DIM) h_eff = DIM_W'(MAX_SOURCE_DIM);
    else h_eff = DIM_W'(src_h_q);
    s_eff  = (scale_q < SCALE_ONE) ? SCALE_ONE : scale_q;
    ow_eff = (int'(out_w_q) > MAX_OUT_WIDTH) ? COL_W'(MAX_OUT_WIDTH) : COL_W'(out_w_q);
  end

  // Position state.
  logic [DIM_W-1:0]  sx_q, sy_q;
  logic [COL_W-1:0]  ocol_q;
  logic [7:0]        orow_q;
  logic [EDGE_W-1:0] nce_q;
  logic [19:0]       wsr_q;

  logic [DIM_W-1:0]  sx, sy;
  logic [COL_W-1:0]  ocol, col;
  logic [7:0]        orow;
  logic [EDGE_W-1:0] nce, nce_n;
  logic [19:0]       wsr;
  logic [DIM_W:0]    sx_p1, sy_p1;
  logic [12:0]       row_end_raw;
  logic [RE_W-1:0]   row_end;
  logic              adv, row_in, last_row, acc, col_end_hit, emit, wrap, fdone;

  always_comb begin
    sx   = frame_start_i ? '0 : sx_q;
    sy   = frame_start_i ? '0 : sy_q;
    ocol = frame_start_i ? '0 : ocol_q;
    orow = frame_start_i ? '0 : orow_q;
    nce  = frame_start_i ? EDGE_W'(s_eff) : nce_q;
    wsr  = frame_start_i ? '0 : wsr_q;

    adv   = (ocol < ow_eff) && (sx >= nce[EDGE_W-1:8]);
    col   = ocol + COL_W'(adv);
    nce_n = adv ? nce + EDGE_W'(s_eff) : nce;

    row_end_raw = {1'b0, wsr[19:8]} + 13'(s_eff[11:8]);
    row_end     = (RE_W'(row_end_raw) > RE_W'(h_eff)) ? RE_W'(h_eff) : RE_W'(row_end_raw);
    sx_p1       = {1'b0, sx} + (DIM_W + 1)'(1);
    sy_p1       = {1'b0, sy} + (DIM_W + 1)'(1);
    row_in      = (orow < out_h_q) && (sy >= wsr[19:8]) && (sy < row_end);
    last_row    = row_in && (sy_p1 == row_end);
    acc         = row_in && (col < ow_eff) && (sx < w_eff);

    // The column window ends at its edge, or at the image edge if that comes first.
    if (nce_n[EDGE_W-1:8] > w_eff) col_end_hit = (sx_p1 == w_eff);
    else col_end_hit = (sx_p1 == nce_n[EDGE_W-1:8]);
    emit  = acc && last_row && col_end_hit;
    wrap  = (sx_p1 >= w_eff);
    fdone = (({1'b0, orow} + 9'd1) == {1'b0, out_h_q}) && ((col + COL_W'(1)) == ow_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= '0;
      sy_q   <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      nce_q  <= EDGE_W'(RST_SCALE_Q8);
      wsr_q  <= '0;
    end else if (cmd_i.accept) begin
      if (wrap) begin
        sx_q   <= '0;
        ocol_q <= '0;
        nce_q  <= EDGE_W'(s_eff);
        orow_q <= last_row ? orow + 8'd1 : orow;
        wsr_q  <= last_row ? wsr + 20'(s_eff) : wsr;
        sy_q   <= (sy < h_eff) ? DIM_W'(sy_p1) : sy;
      end else begin
        sx_q   <= DIM_W'(sx_p1);
        ocol_q <= col;
        nce_q  <= nce_n;
        orow_q <= orow;
        wsr_q  <= wsr;
        sy_q   <= sy;
      end
    end
  end

  // Item registers, loaded on accept.
  logic [LANES-1:0][LIN_W-1:0] lin_q;
  logic [ADDR_W-1:0]           addr_q;
  logic                        acc_q, emit_q, fdone_q;
  logic [6:0]                  col_q, row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 1'b0;
      emit_q <= 1'b0;
    end else if (cmd_i.accept) begin
      acc_q  <= acc;
      emit_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lin_q[0] <= EXPAND_LUT[red_in_i];
      lin_q[1] <= EXPAND_LUT[green_in_i];
      lin_q[2] <= EXPAND_LUT[blue_in_i];
      addr_q   <= col[ADDR_W-1:0];
      col_q    <= 7'(col);
      row_q    <= orow[6:0];
      fdone_q  <= fdone;
    end
  end

  // Column accumulator memory: three sums and a count per output column.
  // Entries without a valid bit read as zero; frame start drops all valid bits.
  logic [WORD_W-1:0]        mem [MAX_OUT_WIDTH];
  logic [WORD_W-1:0]        rd_q, base, wr_word;
  logic [MAX_OUT_WIDTH-1:0] vld_q;
  logic [LANES-1:0][SUM_W-1:0] sums;
  logic [CNT_W-1:0]         cnt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) rd_q <= mem[col[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_step && acc_q) mem[addr_q] <= wr_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.accept && frame_start_i) begin
      vld_q <= '0;
    end else if (cmd_i.acc_step && acc_q) begin
      vld_q[addr_q] <= !emit_q;
    end
  end

  always_comb begin
    base = vld_q[addr_q] ? rd_q : '0;
    for (int l = 0; l < LANES; l++) begin
      sums[l] = base[CNT_W + l*SUM_W +: SUM_W] + SUM_W'(lin_q[l]);
    end
    cnt     = base[CNT_W-1:0] + CNT_W'(1);
    wr_word = {sums, cnt};
  end

  // Averages: sums divided by the pixel count, a zero count counting as one.
  logic                        div_done;
  logic [LANES-1:0][SUM_W-1:0] quo;

  gcbd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.acc_step && emit_q),
    .dividend_i (sums),
    .divisor_i  ((cnt == '0) ? CNT_W'(1) : cnt),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Output register.
  logic                        out_valid_q;
  logic [LANES-1:0][7:0]       pix_q;
  logic [6:0]                  ocol_out_q, orow_out_q;
  logic                        fdone_out_q;
  logic [LANES-1:0][CIDX_W-1:0] cidx;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cidx[l] = (quo[l][SUM_W-1:LIN_W] != '0) ? '1 : quo[l][LIN_W-1:LIN_W-CIDX_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      for (int l = 0; l < LANES; l++) pix_q[l] <= COMPRESS_LUT[cidx[l]];
      ocol_out_q  <= col_q;
      orow_out_q  <= row_q;
      fdone_out_q <= fdone_q;
    end
  end

  assign status_o.emit     = emit_q;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = pix_q[0];
  assign green_out_o  = pix_q[1];
  assign blue_out_o   = pix_q[2];
  assign out_column_o = ocol_out_q;
  assign out_row_o    = orow_out_q;
  assign frame_done_o = fdone_out_q;

endmodule

// ===== src/gamma_correct_box_downscaler_core.sv =====
// ----------------------------------------------------------------------------
// gamma_correct_box_downscaler_core
// Gamma-correct box-filter downscaler for a raster stream of RGB pixels.
// ----------------------------------------------------------------------------
// Usage: source pixels arrive in raster order on in_ch, one item per pixel;
// frame_start marks the first pixel of a frame and restarts all positions and
// clears every column accumulator. Averaged pixels leave on out_ch, each with
// its output column and row, and frame_done on the last pixel of the frame.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Item flow: an item that closes no window is accepted, then the
// read-modify-write of its column accumulator follows. An item that closes a
// window is accepted and accumulated, divided in the bit-serial divider, and
// then loaded into the output register, which raises out_ch.valid. A new item
// is accepted only after the sequencer has returned to idle.
// The output register lets the next item enter while a result waits; if
// the receiver keeps stalling, the next window-closing item waits after its
// division until the output register is free, and in_ch.ready stays low.
// Reset returns the registers to their defaults, empties the output register
// and clears every accumulator at once through its valid bit.
// ----------------------------------------------------------------------------
module gamma_correct_box_downscaler_core
  import gcbd_pkg::*;
#(
  parameter int MAX_OUT_WIDTH  = MAX_OUT_WIDTH_DEF,
  parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gcbd_in_if.sink               in_ch,
  gcbd_out_if.source            out_ch
);

  // Command and status between sequencer and datapath.
  cmd_t    cmd;
  status_t status;

  gcbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gcbd_datapath #(
    .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
    .MAX_SOURCE_DIM (MAX_SOURCE_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .red_in_i      (in_ch.red_in),
    .green_in_i    (in_ch.green_in),
    .blue_in_i     (in_ch.blue_in),
    .frame_start_i (in_ch.frame_start),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .red_out_o     (out_ch.red_out),
    .green_out_o   (out_ch.green_out),
    .blue_out_o    (out_ch.blue_out),
    .out_column_o  (out_ch.out_column),
    .out_row_o     (out_ch.out_row),
    .frame_done_o  (out_ch.frame_done)
  );

endmodule
